// File: rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg: shared types and constants of the RIFF chunk walker
// Register indexes, status codes, walk phases and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

    // widths and sizes
    localparam int OFFSET_BITS_DEF = 32;
    localparam int WORD_W          = 32;
    localparam int CEND_W          = WORD_W + 2;   // chunk end compare, never wraps
    localparam int HDR_LEN         = 8;            // code + size
    localparam int TYPE_LEN        = 4;            // list type bytes
    localparam int CFG_IDX_W       = 3;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUFFER_LENGTH = 3'd0,
        REG_FILTER_MODE   = 3'd1,
        REG_MATCH_CODE    = 3'd2,
        REG_MATCH_TYPE    = 3'd3,
        REG_FIRST_ONLY    = 3'd4
    } rcw_reg_e;

    // filter modes; the remaining code matches nothing
    localparam logic [1:0] FILT_ALL  = 2'd0;
    localparam logic [1:0] FILT_CODE = 2'd1;
    localparam logic [1:0] FILT_LIST = 2'd2;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_END     = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_OVERRUN = 2'd3
    } rcw_status_e;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_DONE   = 2'd2
    } rcw_phase_e;

    typedef struct packed {
        logic [WORD_W-1:0] buffer_length;
        logic [1:0]        filter_mode;
        logic [WORD_W-1:0] match_code;
        logic [WORD_W-1:0] match_type;
        logic              first_only;
    } rcw_cfg_t;

    typedef struct packed {
        rcw_status_e       status;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] code;
        logic [WORD_W-1:0] size;
        logic              last;
    } rcw_result_t;

endpackage

`default_nettype wire

// File: rtl/rcw_in_if.sv
// ----------------------------------------------------------------------------
// rcw_in_if: byte channel into the walker
// One buffer byte per transaction, with a start-of-buffer mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_start;

    modport source (output valid, output data_byte, output buffer_start, input ready);
    modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

`default_nettype wire

// File: rtl/rcw_out_if.sv
// ----------------------------------------------------------------------------
// rcw_out_if: result channel out of the walker
// One matching chunk or walk status per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcw_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [rcw_pkg::WORD_W-1:0] chunk_offset;
    logic [rcw_pkg::WORD_W-1:0] chunk_code;
    logic [rcw_pkg::WORD_W-1:0] chunk_size;
    logic                      last_result;

    modport source (output valid, output status, output chunk_offset, output chunk_code,
                    output chunk_size, output last_result, input ready);
    modport sink   (input valid, input status, input chunk_offset, input chunk_code,
                    input chunk_size, input last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/rcw_core.sv
// ----------------------------------------------------------------------------
// rcw_core: chunk walk state and per-byte decision logic
// Updates the walk state for one byte and yields up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_core #(
    parameter int OFFSET_BITS = rcw_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 proc,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_start,
    input  wire rcw_pkg::rcw_cfg_t    cfg,
    output logic [1:0]                res_cnt,
    output rcw_pkg::rcw_result_t      res0,
    output rcw_pkg::rcw_result_t      res1
);

    localparam int CW = rcw_pkg::CEND_W;
    localparam int WW = rcw_pkg::WORD_W;
    localparam logic [WW:0]  LEN_MAX      = ((WW+1)'(1) << OFFSET_BITS) - (WW+1)'(1);
    localparam logic [2:0]   CNT_HDR_LAST = 3'(rcw_pkg::HDR_LEN - 1);
    localparam logic [2:0]   CNT_TYP_LAST = 3'(rcw_pkg::TYPE_LEN - 1);
    localparam logic [2:0]   CNT_TYP_DONE = 3'(rcw_pkg::TYPE_LEN);

    // walk state
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] hs_reg, hs_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   found_reg, found_next;
    rcw_pkg::rcw_phase_e    phase_reg, phase_next;
    logic [2*WW-1:0]        hdr_reg, hdr_next;
    logic [WW-1:0]          type_reg, type_next;
    logic [CW-1:0]          cend_reg, cend_next;

    // start-of-buffer view of the state
    logic [OFFSET_BITS-1:0] pos_eff, hs_eff;
    logic [2:0]             cnt_eff;
    logic                   found_eff;
    rcw_pkg::rcw_phase_e    phase_eff;

    logic [WW-1:0]          len32;
    logic [CW-1:0]          len34, p34, end_q, cend_w;
    logic [WW-1:0]          code_w, size_w;
    logic                   hdr_ok, typ_done, want_match, end_chk;
    logic                   m_vld, t_vld;
    rcw_pkg::rcw_result_t   m_res, t_res;

    function automatic logic hdr_short(input logic [CW-1:0] q, input logic [CW-1:0] l);
        return (q + CW'(rcw_pkg::HDR_LEN)) > l;
    endfunction

    function automatic rcw_pkg::rcw_status_e hdr_status(input logic [CW-1:0] q,
                                                        input logic [CW-1:0] l);
        return (q >= l) ? rcw_pkg::ST_END : rcw_pkg::ST_TRUNC;
    endfunction

    function automatic rcw_pkg::rcw_result_t mk_res(input rcw_pkg::rcw_status_e st,
                                                    input logic [WW-1:0] off,
                                                    input logic [WW-1:0] code,
                                                    input logic [WW-1:0] size);
        rcw_pkg::rcw_result_t r;
        r.status = st;
        r.offset = off;
        r.code   = code;
        r.size   = size;
        r.last   = 1'b0;
        return r;
    endfunction

    // buffer length saturated to the offset range
    assign len32 = (cfg.buffer_length > LEN_MAX[WW-1:0]) ? LEN_MAX[WW-1:0]
                                                         : cfg.buffer_length;
    assign len34 = CW'(len32[OFFSET_BITS-1:0]);

    // buffer start clears the walk before this byte
    assign pos_eff   = in_start ? '0 : pos_reg;
    assign hs_eff    = in_start ? '0 : hs_reg;
    assign cnt_eff   = in_start ? '0 : cnt_reg;
    assign found_eff = in_start ? 1'b0 : found_reg;
    assign phase_eff = in_start ? rcw_pkg::PH_HEADER : phase_reg;
    assign p34       = CW'(pos_eff);

    // next state and results
    always_comb
    begin
        pos_next   = OFFSET_BITS'(pos_eff + 1'b1);
        hs_next    = hs_eff;
        cnt_next   = cnt_eff;
        found_next = found_eff;
        phase_next = phase_eff;
        hdr_next   = hdr_reg;
        type_next  = type_reg;
        cend_next  = cend_reg;
        cend_w     = cend_reg;
        hdr_ok     = 1'b0;
        typ_done   = 1'b0;
        end_chk    = 1'b0;
        end_q      = cend_reg;
        t_vld      = 1'b0;
        t_res      = mk_res(rcw_pkg::ST_END, '0, '0, '0);

        case (phase_eff)
            rcw_pkg::PH_HEADER:
            begin
                if (cnt_eff == 3'd0 && hdr_short(p34, len34))
                begin
                    t_vld      = 1'b1;
                    t_res      = mk_res(hdr_status(p34, len34), WW'(pos_eff), '0, '0);
                    phase_next = rcw_pkg::PH_DONE;
                end
                else
                begin
                    hdr_next[{cnt_eff, 3'b000} +: 8] = in_byte;
                    if (cnt_eff == CNT_HDR_LAST)
                    begin
                        // header complete: padded chunk must fit
                        cend_w = CW'(hs_eff) + CW'(rcw_pkg::HDR_LEN)
                               + CW'(hdr_next[2*WW-1:WW]) + CW'(hdr_next[WW]);
                        cend_next = cend_w;
                        if (cend_w > len34)
                        begin
                            t_vld      = 1'b1;
                            t_res      = mk_res(rcw_pkg::ST_OVERRUN, WW'(hs_eff),
                                                hdr_next[WW-1:0], hdr_next[2*WW-1:WW]);
                            phase_next = rcw_pkg::PH_DONE;
                        end
                        else
                        begin
                            hdr_ok     = 1'b1;
                            phase_next = rcw_pkg::PH_DATA;
                            cnt_next   = 3'd0;
                            end_chk    = 1'b1;
                            end_q      = cend_w;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_eff + 3'd1;
                    end
                end
            end
            rcw_pkg::PH_DATA:
            begin
                // first four data bytes form the list type
                if (cnt_eff < CNT_TYP_DONE)
                begin
                    type_next[{cnt_eff[1:0], 3'b000} +: 8] = in_byte;
                    typ_done = (cnt_eff == CNT_TYP_LAST);
                    cnt_next = cnt_eff + 3'd1;
                end
                end_chk = 1'b1;
                end_q   = cend_reg;
            end
            default:
            begin
            end
        endcase

        // filter
        code_w = hdr_next[WW-1:0];
        size_w = hdr_next[2*WW-1:WW];
        want_match = (hdr_ok && (cfg.filter_mode == rcw_pkg::FILT_ALL ||
                                 (cfg.filter_mode == rcw_pkg::FILT_CODE &&
                                  code_w == cfg.match_code)))
                  || (typ_done && cfg.filter_mode == rcw_pkg::FILT_LIST &&
                      code_w == cfg.match_code && size_w >= WW'(rcw_pkg::TYPE_LEN) &&
                      type_next == cfg.match_type);

        m_vld = 1'b0;
        m_res = mk_res(rcw_pkg::ST_MATCH, WW'(hs_eff), code_w, size_w);
        if (want_match && !(cfg.first_only && found_eff))
        begin
            m_vld      = 1'b1;
            found_next = 1'b1;
        end

        // end of chunk: next header must fit
        if (end_chk && (p34 + CW'(1)) == end_q)
        begin
            hs_next    = end_q[OFFSET_BITS-1:0];
            cnt_next   = 3'd0;
            phase_next = rcw_pkg::PH_HEADER;
            if (hdr_short(end_q, len34))
            begin
                t_vld      = 1'b1;
                t_res      = mk_res(hdr_status(end_q, len34),
                                    WW'(end_q[OFFSET_BITS-1:0]), '0, '0);
                phase_next = rcw_pkg::PH_DONE;
            end
        end

        // done: only the position counter moves
        if (phase_eff == rcw_pkg::PH_DONE)
        begin
            m_vld = 1'b0;
            t_vld = 1'b0;
        end

        // order: match first, then status
        res0      = m_vld ? m_res : t_res;
        res0.last = !(m_vld && t_vld);
        res1      = t_res;
        res1.last = 1'b1;
        res_cnt   = proc ? ({1'b0, m_vld} + {1'b0, t_vld}) : 2'd0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hs_reg    <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            phase_reg <= rcw_pkg::PH_HEADER;
        end
        else if (proc)
        begin
            pos_reg   <= pos_next;
            hs_reg    <= hs_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            phase_reg <= phase_next;
        end
    end

    // header, type and chunk end
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            hdr_reg  <= hdr_next;
            type_reg <= type_next;
            cend_reg <= cend_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rcw_res_fifo.sv
// ----------------------------------------------------------------------------
// rcw_res_fifo: result queue
// Takes up to two results per cycle, hands out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_res_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            wr_cnt,
    input  wire rcw_pkg::rcw_result_t  wr0,
    input  wire rcw_pkg::rcw_result_t  wr1,
    input  wire logic                  pop,
    output rcw_pkg::rcw_result_t       head,
    output logic                       not_empty,
    output logic                       room2
);

    localparam int PW = rcw_pkg::RES_PTR_W;
    localparam int CW = rcw_pkg::RES_CNT_W;

    rcw_pkg::rcw_result_t entry_reg [rcw_pkg::RES_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr_p1;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign wr_ptr_p1 = PW'(wr_ptr_reg + 1'b1);
    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= CW'(rcw_pkg::RES_DEPTH - 2));

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = PW'(wr_ptr_reg + wr_cnt);
        rd_ptr_next = PW'(rd_ptr_reg + pop);
        cnt_next    = CW'(cnt_reg + CW'(wr_cnt) - CW'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= wr0;
        end
        if (wr_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_p1] <= wr1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/riff_chunk_walker_unit.sv
// Flow: an accepted byte waits in the input register until the result queue has room
// for two results; it is then decided and its results are written into the result queue.
// Throughput: one byte per cycle; a byte yielding two results needs two output
// transactions, absorbed by a four-entry result queue (input holds when < 2 free).
// Reset: walk state back to the header phase at offset 0, configuration registers
// zero, result queue empty; the block is usable as soon as reset is released.
// ----------------------------------------------------------------------------
// riff_chunk_walker_unit: RIFF chunk walker, top level
// Input register, walk decision logic, result queue and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_chunk_walker_unit #(
    parameter int OFFSET_BITS = rcw_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rcw_in_if.sink                             item,
    rcw_out_if.source                          result,
    input  wire logic                          cfg_we,
    input  wire logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcw_pkg::WORD_W-1:0]    cfg_data
);

    rcw_pkg::rcw_cfg_t    cfg_reg, cfg_next;
    logic                 in_vld_reg, in_vld_next;
    logic [7:0]           in_byte_reg;
    logic                 in_start_reg;
    logic                 accept, proc, room2, not_empty, pop;
    logic [1:0]           res_cnt;
    rcw_pkg::rcw_result_t res0, res1, head;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (rcw_pkg::rcw_reg_e'(cfg_index))
                rcw_pkg::REG_BUFFER_LENGTH: cfg_next.buffer_length = cfg_data;
                rcw_pkg::REG_FILTER_MODE:   cfg_next.filter_mode   = cfg_data[1:0];
                rcw_pkg::REG_MATCH_CODE:    cfg_next.match_code    = cfg_data;
                rcw_pkg::REG_MATCH_TYPE:    cfg_next.match_type    = cfg_data;
                rcw_pkg::REG_FIRST_ONLY:    cfg_next.first_only    = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input register: a byte is decided once the queue has room for two results
    assign proc        = in_vld_reg && room2;
    assign item.ready  = !in_vld_reg || proc;
    assign accept      = item.valid && item.ready;
    assign in_vld_next = accept || (in_vld_reg && !proc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= item.data_byte;
            in_start_reg <= item.buffer_start;
        end
    end

    rcw_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .proc     (proc),
        .in_byte  (in_byte_reg),
        .in_start (in_start_reg),
        .cfg      (cfg_reg),
        .res_cnt  (res_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    rcw_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (res_cnt),
        .wr0       (res0),
        .wr1       (res1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    // result channel
    assign pop                 = result.valid && result.ready;
    assign result.valid        = not_empty;
    assign result.status       = head.status;
    assign result.chunk_offset = head.offset;
    assign result.chunk_code   = head.code;
    assign result.chunk_size   = head.size;
    assign result.last_result  = head.last;

endmodule

`default_nettype wire

// File: rtl/rcw_checker.sv
// ----------------------------------------------------------------------------
// rcw_checker: port-level checks of the chunk walker
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [1:0]                 status,
    input wire logic [rcw_pkg::WORD_W-1:0] chunk_code,
    input wire logic [rcw_pkg::WORD_W-1:0] chunk_size,
    input wire logic                       last_result
);

    // a pending result transaction is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // a walk status always closes the results of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != rcw_pkg::ST_MATCH |-> last_result)
        else $error("walk status not marked last");

    // end and truncation carry no chunk code or size
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rcw_pkg::ST_END || status == rcw_pkg::ST_TRUNC)
        |-> chunk_code == '0 && chunk_size == '0)
        else $error("end status with chunk fields set");

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind riff_chunk_walker_unit rcw_checker u_rcw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .status      (result.status),
    .chunk_code  (result.chunk_code),
    .chunk_size  (result.chunk_size),
    .last_result (result.last_result)
);

`default_nettype wire

// File: tb/rcw_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcw_walk_checker: result predictor and scoreboard for the RIFF chunk walker
// Watches the byte, result and register ports. Each accepted byte goes through
// a local model of the chunk walk, and the results it predicts are queued in
// order. Each result transaction is compared field by field with the oldest
// queued prediction.
// ----------------------------------------------------------------------------
module rcw_walk_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    rcw_in_if                             item,
    rcw_out_if                            result,
    input  logic                          cfg_we,
    input  logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcw_pkg::WORD_W-1:0]    cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import rcw_pkg::*;

    localparam int SHOWN_MAX = 10;

    // local copy of the registers and of the walk state
    rcw_cfg_t          regs;
    logic [31:0]       byte_pos;
    logic [31:0]       hdr_start;
    logic [63:0]       hdr_bytes;
    logic [31:0]       list_type;
    logic [CEND_W-1:0] chunk_end;
    rcw_phase_e        phase;
    logic              found;

    rcw_result_t       chunk_reports[$];
    rcw_result_t       seen;
    rcw_result_t       want;
    int                shown;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        shown      = 0;
    end

    task automatic push_report(input rcw_status_e st, input logic [CEND_W-1:0] off,
                               input logic [31:0] cd, input logic [31:0] sz);
        rcw_result_t r;
        r.status = st;
        r.offset = off[WORD_W-1:0];
        r.code   = cd;
        r.size   = sz;
        r.last   = 1'b0;
        chunk_reports.insert(chunk_reports.size(), r);
    endtask

    // a header must fit at offset q, otherwise the walk ends here
    task automatic check_header(input logic [CEND_W-1:0] q);
        if (q >= {2'b00, regs.buffer_length})
        begin
            phase = PH_DONE;
            push_report(ST_END, q, '0, '0);
        end
        else if (q + CEND_W'(HDR_LEN) > {2'b00, regs.buffer_length})
        begin
            phase = PH_DONE;
            push_report(ST_TRUNC, q, '0, '0);
        end
    endtask

    task automatic report_match(input logic [31:0] cd, input logic [31:0] sz);
        if (!(regs.first_only && found))
        begin
            found = 1'b1;
            push_report(ST_MATCH, {2'b00, hdr_start}, cd, sz);
        end
    endtask

    // advance the walk by one byte and queue the results it causes
    task automatic walk_byte(input logic [7:0] b, input logic start);
        int          first_new;
        logic [31:0] pos;
        logic [2:0]  hidx;
        logic [31:0] didx;
        logic [31:0] cd;
        logic [31:0] sz;
        rcw_result_t tail;
        first_new = chunk_reports.size();
        if (start)
        begin
            byte_pos  = '0;
            hdr_start = '0;
            hdr_bytes = '0;
            list_type = '0;
            chunk_end = '0;
            phase     = PH_HEADER;
            found     = 1'b0;
        end
        pos      = byte_pos;
        byte_pos = pos + 32'd1;
        if (phase == PH_DONE)
            return;

        cd = hdr_bytes[31:0];
        sz = hdr_bytes[63:32];

        if (phase == PH_HEADER)
        begin
            hidx = 3'(pos - hdr_start);
            if (hidx == 3'd0)
                check_header({2'b00, pos});
            if (phase == PH_HEADER)
            begin
                hdr_bytes = hdr_bytes | (64'(b) << (8 * hidx));
                if (hidx == 3'd7)
                begin
                    cd = hdr_bytes[31:0];
                    sz = hdr_bytes[63:32];
                    // padded end, 34 bits so it cannot wrap
                    chunk_end = {2'b00, hdr_start} + CEND_W'(HDR_LEN) + {2'b00, sz}
                              + CEND_W'(sz[0]);
                    if (chunk_end > {2'b00, regs.buffer_length})
                    begin
                        phase = PH_DONE;
                        push_report(ST_OVERRUN, {2'b00, hdr_start}, cd, sz);
                    end
                    else
                    begin
                        if (regs.filter_mode == FILT_ALL ||
                            (regs.filter_mode == FILT_CODE && cd == regs.match_code))
                            report_match(cd, sz);
                        phase     = PH_DATA;
                        list_type = '0;
                    end
                end
            end
        end
        else
        begin
            // list type sits in data bytes 0..3
            didx = pos - hdr_start - 32'd8;
            if (didx < 32'(TYPE_LEN))
            begin
                list_type = list_type | (32'(b) << (8 * didx));
                if (didx == 32'd3 && regs.filter_mode == FILT_LIST &&
                    cd == regs.match_code && sz >= 32'd4 && list_type == regs.match_type)
                    report_match(cd, sz);
            end
        end

        // last byte of the chunk: the next header must fit
        if (phase == PH_DATA && {2'b00, pos} + CEND_W'(1) == chunk_end)
        begin
            hdr_start = chunk_end[31:0];
            hdr_bytes = '0;
            phase     = PH_HEADER;
            check_header(chunk_end);
        end

        if (chunk_reports.size() > first_new)
        begin
            tail      = chunk_reports[chunk_reports.size() - 1];
            tail.last = 1'b1;
            chunk_reports[chunk_reports.size() - 1] = tail;
        end
    endtask

    // compare, track registers, predict
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs      = '0;
            byte_pos  = '0;
            hdr_start = '0;
            hdr_bytes = '0;
            list_type = '0;
            chunk_end = '0;
            phase     = PH_HEADER;
            found     = 1'b0;
            chunk_reports.delete();
            pending   = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen.status = rcw_status_e'(result.status);
                seen.offset = result.chunk_offset;
                seen.code   = result.chunk_code;
                seen.size   = result.chunk_size;
                seen.last   = result.last_result;
                if (chunk_reports.size() == 0)
                begin
                    fail_count++;
                    if (shown < SHOWN_MAX)
                    begin
                        shown++;
                        $display("%0t: extra result: st %0d off %h code %h size %h last %0d",
                                 $realtime, seen.status, seen.offset, seen.code, seen.size,
                                 seen.last);
                    end
                end
                else
                begin
                    want = chunk_reports.pop_front();
                    if (seen.status !== want.status || seen.offset !== want.offset ||
                        seen.code !== want.code || seen.size !== want.size ||
                        seen.last !== want.last)
                    begin
                        fail_count++;
                        if (shown < SHOWN_MAX)
                        begin
                            shown++;
                            $display("%0t: expected st %0d off %h code %h size %h last %0d",
                                     $realtime, want.status, want.offset, want.code, want.size,
                                     want.last);
                            $display("%0t: actual   st %0d off %h code %h size %h last %0d",
                                     $realtime, seen.status, seen.offset, seen.code, seen.size,
                                     seen.last);
                        end
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BUFFER_LENGTH: regs.buffer_length = cfg_data;
                    REG_FILTER_MODE:   regs.filter_mode   = cfg_data[1:0];
                    REG_MATCH_CODE:    regs.match_code    = cfg_data;
                    REG_MATCH_TYPE:    regs.match_type    = cfg_data;
                    REG_FIRST_ONLY:    regs.first_only    = cfg_data[0];
                    default: ;
                endcase
            end

            if (item.valid && item.ready)
                walk_byte(item.data_byte, item.buffer_start);

            pending = chunk_reports.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the RIFF chunk walker
// Writes the registers between phases and streams buffers of RIFF chunks,
// mostly well formed with random codes, sizes and list types, some pure noise.
// Both handshake sides stall at random. Prediction and checking are done by
// rcw_walk_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import rcw_pkg::*;

    localparam int         ITEM_TARGET   = 2000;
    localparam int         GAP_MAX       = 13;
    localparam int         SMALL_LEN_MAX = 64;
    localparam int         SETTLE_CYCLES = 4;
    localparam logic [1:0] FILT_NONE     = 2'd3;   // matches no chunk

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;

    logic                 send_calm;
    logic                 recv_calm;
    logic [31:0]          cur_len;
    logic [31:0]          cur_code;
    logic [31:0]          cur_type;
    logic [1:0]           cur_mode;
    logic [7:0]           riff_bytes[$];
    int                   total_bytes;
    int                   send_len;
    int                   pick;
    int                   k;
    int                   recv_stall;

    rcw_in_if  item_ch ();
    rcw_out_if result_ch ();

    riff_chunk_walker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rcw_walk_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("testbench failed");
        $finish;
    end

    // one byte transaction, after a random hold-off
    task automatic send_byte(input logic [7:0] value, input logic start);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.data_byte    <= value;
        item_ch.buffer_start <= start;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    // stop sending and let every predicted result drain
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input rcw_reg_e idx, input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // chunks with codes near the match code, small sizes, now and then a huge one
    task automatic make_buffer(input int want, input logic noise);
        logic [31:0] cd;
        logic [31:0] sz;
        logic        type_hit;
        int          j;
        riff_bytes.delete();
        while (!noise && riff_bytes.size() < want)
        begin
            case ($urandom_range(0, 3))
                0, 1:    cd = cur_code;
                2:       cd = cur_code ^ (32'd1 << $urandom_range(0, 31));
                default: cd = $urandom;
            endcase
            sz       = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20);
            type_hit = $urandom_range(0, 1);
            for (j = 0; j < 4; j++) riff_bytes.insert(riff_bytes.size(), cd[8*j +: 8]);
            for (j = 0; j < 4; j++) riff_bytes.insert(riff_bytes.size(), sz[8*j +: 8]);
            if (sz > 32'd64)
                break;
            for (j = 0; j < int'(sz) + int'(sz[0]); j++)
                riff_bytes.insert(riff_bytes.size(),
                                  (j < TYPE_LEN && type_hit) ? cur_type[8*j +: 8]
                                                             : 8'($urandom));
        end
        while (riff_bytes.size() < want) riff_bytes.insert(riff_bytes.size(), 8'($urandom));
    endtask

    // result side: random stall per transaction
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            recv_stall = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
            @(negedge clk);
            if (recv_stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (recv_stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        item_ch.valid        = 1'b0;
        item_ch.data_byte    = '0;
        item_ch.buffer_start = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        send_calm            = 1'b0;
        recv_calm            = 1'b0;
        total_bytes          = 0;
        cur_code             = '0;
        cur_type             = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // empty buffer straight after reset without a start mark; second byte ignored
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        settle();

        // maximum size overruns even the longest buffer
        write_reg(REG_BUFFER_LENGTH, 32'hFFFF_FFFF);
        cur_code = 32'h4646_4952;
        for (k = 0; k < HDR_LEN; k++)
            send_byte((k < 4) ? cur_code[8*k +: 8] : 8'hFF, k == 0);
        settle();

        // zero header: code match and truncated header on the same byte
        write_reg(REG_BUFFER_LENGTH, 32'd10);
        write_reg(REG_FILTER_MODE, {30'b0, FILT_CODE});
        write_reg(REG_MATCH_CODE, 32'h0);
        write_reg(REG_FIRST_ONLY, 32'd1);
        for (k = 0; k < HDR_LEN; k++)
            send_byte(8'h00, k == 0);
        settle();
        total_bytes = 18;

        // random phases, one register setting each
        while (total_bytes < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       cur_len = 32'd0;
                1:       cur_len = 32'hFFFF_FFFF;
                2:       cur_len = $urandom;
                default: cur_len = $urandom_range(1, SMALL_LEN_MAX);
            endcase
            pick     = $urandom_range(0, 7);
            cur_mode = (pick == 7) ? FILT_NONE : 2'(pick % 3);
            case ($urandom_range(0, 3))
                0:       cur_code = 32'h0;
                1:       cur_code = 32'hFFFF_FFFF;
                default: cur_code = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       cur_type = 32'h0;
                1:       cur_type = 32'hFFFF_FFFF;
                default: cur_type = $urandom;
            endcase
            write_reg(REG_BUFFER_LENGTH, cur_len);
            write_reg(REG_FILTER_MODE, {30'b0, cur_mode});
            write_reg(REG_MATCH_CODE, cur_code);
            write_reg(REG_MATCH_TYPE, cur_type);
            write_reg(REG_FIRST_ONLY, 32'($urandom_range(0, 1)));
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);

            repeat ($urandom_range(1, 4))
            begin
                // short buffers run to their end; long ones are cut off mid-walk
                if (cur_len <= SMALL_LEN_MAX)
                    send_len = int'(cur_len) + $urandom_range(0, 2);
                else
                    send_len = $urandom_range(16, 64);
                if (send_len == 0)
                    send_len = 1;
                make_buffer(send_len, $urandom_range(0, 7) == 0);
                for (k = 0; k < send_len; k++)
                    send_byte(riff_bytes[k], k == 0 || $urandom_range(0, 99) == 0);
                total_bytes += send_len;
            end
            settle();
        end

        settle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
